// ===== sv/spra_pkg.sv =====
// Shared types and constants of the static priority rank assigner.
package spra_pkg;

  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 32;
  localparam int PRIO_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_MEM_W = 2 * TIME_W;

  localparam logic [PRIO_W-1:0] RESET_BASE_PRIO = 6'd5;
  localparam logic [PRIO_W-1:0] PRIO_MAX        = 6'd63;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_DUP  = 2'd1;
  localparam status_t STATUS_MISS = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RANK_MODE = 2'd0;
  localparam cfg_idx_t CFG_BASE_PRIO = 2'd1;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_FINISH  = 1'b1;

  typedef struct packed {
    logic              start;
    status_t           status;
    logic              mode;
    logic [PRIO_W-1:0] base;
  } rank_cmd_t;

endpackage

// ===== sv/spra_key_mem.sv =====
// Task key memory: period and deadline per slot, one write and one registered read port.
module spra_key_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/spra_rank_engine.sv =====
// Rank sequencer: repeated max-key scans with one shared comparator, result register.
module spra_rank_engine #(
  parameter int MAX_TASKS = 16,
  localparam int AW  = $clog2(MAX_TASKS),
  localparam int CW  = $clog2(MAX_TASKS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spra_pkg::rank_cmd_t              cmd,
  input  logic [MAX_TASKS-1:0]             active,
  input  logic [CW-1:0]                    count,
  output logic [AW-1:0]                    rd_addr,
  input  logic [spra_pkg::KEY_MEM_W-1:0]   rd_data,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [spra_pkg::SLOT_W-1:0]      res_slot,
  output logic [spra_pkg::PRIO_W-1:0]      res_prio,
  output logic                             res_empty,
  output spra_pkg::status_t                res_status,
  output logic                             res_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TASKS - 1);

  state_t                              state, state_next;
  logic [AW-1:0]                       idx;
  logic [AW-1:0]                       pend_idx;
  logic                                pend_vld;
  logic [AW-1:0]                       best_idx;
  logic [spra_pkg::TIME_W-1:0]         best_key;
  logic                                found;
  logic [MAX_TASKS-1:0]                emitted;
  logic [AW-1:0]                       rank;
  spra_pkg::status_t                   status;
  logic                                mode;
  logic [spra_pkg::PRIO_W-1:0]         base;
  logic [spra_pkg::TIME_W-1:0]         key;
  logic                                take;
  logic                                res_free;
  logic                                last_hit;
  logic [spra_pkg::PRIO_W:0]           prio_sum;
  logic [spra_pkg::PRIO_W-1:0]         prio_sat;

  assign rd_addr  = idx;
  assign idle     = (state == ST_IDLE);
  assign key      = mode ? rd_data[spra_pkg::KEY_MEM_W-1:spra_pkg::TIME_W]
                         : rd_data[spra_pkg::TIME_W-1:0];
  assign take     = pend_vld && (!found || (key > best_key));
  assign res_free = !res_valid || res_ready;
  assign last_hit = ((CW'(rank) + CW'(1)) == count);
  assign prio_sum = {1'b0, base} + (spra_pkg::PRIO_W + 1)'(rank);
  assign prio_sat = prio_sum[spra_pkg::PRIO_W] ? spra_pkg::PRIO_MAX
                                               : prio_sum[spra_pkg::PRIO_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = (count == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_free) begin
          state_next = last_hit ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend_vld  <= 1'b0;
      found     <= 1'b0;
      emitted   <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      pend_vld <= (state == ST_SCAN) && active[idx] && !emitted[idx];
      if (take) begin
        found <= 1'b1;
      end
      if ((state == ST_IDLE) && cmd.start) begin
        emitted <= '0;
        found   <= 1'b0;
      end
      if ((state == ST_EMIT) && res_free) begin
        emitted[best_idx] <= 1'b1;
        found             <= 1'b0;
      end
      if (((state == ST_EMIT) || (state == ST_EMPTY)) && res_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= idx;
    if (take) begin
      best_key <= key;
      best_idx <= pend_idx;
    end
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          status <= cmd.status;
          mode   <= cmd.mode;
          base   <= cmd.base;
          rank   <= '0;
          idx    <= '0;
        end
      end
      ST_SCAN: begin
        idx <= idx + AW'(1);
      end
      ST_DRAIN: begin
        idx <= '0;
      end
      ST_EMIT: begin
        if (res_free) begin
          res_slot   <= spra_pkg::SLOT_W'(best_idx);
          res_prio   <= prio_sat;
          res_empty  <= 1'b0;
          res_status <= status;
          res_last   <= last_hit;
          rank       <= rank + AW'(1);
          idx        <= '0;
        end
      end
      ST_EMPTY: begin
        if (res_free) begin
          res_slot   <= '0;
          res_prio   <= '0;
          res_empty  <= 1'b1;
          res_status <= status;
          res_last   <= 1'b1;
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule

// ===== sv/static_priority_rank_assigner_top.sv =====
// Top level of the static priority rank assigner: config, task table and rank sequencer.
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata: slot, period, deadline; tuser: operation
// m_axis   out  m_axis_tvalid/tready    tdata: task_slot, priority_res; tuser: table_empty,
//                                       status; tlast: last
// cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each item first updates the table, then per active task the sequencer runs one scan of all
// MAX_TASKS slots through the single key memory read port and comparator; an empty table
// yields a single empty result.
// s_axis_tready is low while the sequencer works; a stalled m_axis holds the sequencer.
// Reset is synchronous; it clears the task table and loads the register defaults.
module static_priority_rank_assigner_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [71:0]                    s_axis_tdata,  // slot, period, deadline, zero pad
  input  logic [0:0]                     s_axis_tuser,  // operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // task_slot, priority_res, zero pad
  output logic [2:0]                     m_axis_tuser,  // table_empty, status
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  spra_pkg::cfg_idx_t             cfg_index,
  input  logic [spra_pkg::PRIO_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic                                rank_mode;
  logic [spra_pkg::PRIO_W-1:0]         base_priority;
  logic [MAX_TASKS-1:0]                active;
  logic [CW-1:0]                       active_count;
  spra_pkg::rank_cmd_t                 cmd;
  logic                                cmd_start;
  spra_pkg::status_t                   cmd_status;
  logic                                in_xfer;
  logic                                in_op;
  logic [spra_pkg::SLOT_W-1:0]         in_slot;
  logic [spra_pkg::TIME_W-1:0]         in_period;
  logic [spra_pkg::TIME_W-1:0]         in_deadline;
  logic [AW-1:0]                       sidx;
  logic                                in_range;
  logic                                hit;
  logic                                do_insert;
  logic                                do_remove;
  logic                                eng_idle;
  logic [AW-1:0]                       rd_addr;
  logic [spra_pkg::KEY_MEM_W-1:0]      rd_data;
  logic [spra_pkg::SLOT_W-1:0]         res_slot;
  logic [spra_pkg::PRIO_W-1:0]         res_prio;
  logic                                res_empty;
  spra_pkg::status_t                   res_status;

  assign in_op       = s_axis_tuser[0];
  assign in_slot     = s_axis_tdata[3:0];
  assign in_period   = s_axis_tdata[35:4];
  assign in_deadline = s_axis_tdata[67:36];

  assign s_axis_tready = eng_idle && !cmd_start;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign sidx      = AW'(in_slot);
  assign in_range  = ({28'd0, in_slot} < 32'(MAX_TASKS));
  assign hit       = in_range && active[sidx];
  assign do_insert = in_xfer && (in_op == spra_pkg::OP_RELEASE) && in_range && !hit;
  assign do_remove = in_xfer && (in_op == spra_pkg::OP_FINISH) && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_mode     <= 1'b0;
      base_priority <= spra_pkg::RESET_BASE_PRIO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spra_pkg::CFG_RANK_MODE: rank_mode     <= cfg_data[0];
        spra_pkg::CFG_BASE_PRIO: base_priority <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      active_count <= '0;
      cmd_start    <= 1'b0;
    end else begin
      cmd_start <= in_xfer;
      if (do_insert) begin
        active[sidx] <= 1'b1;
        active_count <= active_count + CW'(1);
      end else if (do_remove) begin
        active[sidx] <= 1'b0;
        active_count <= active_count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (in_op == spra_pkg::OP_RELEASE) begin
        cmd_status <= hit || !in_range ? spra_pkg::STATUS_DUP : spra_pkg::STATUS_OK;
      end else begin
        cmd_status <= hit ? spra_pkg::STATUS_OK : spra_pkg::STATUS_MISS;
      end
    end
  end

  assign cmd = '{start: cmd_start, status: cmd_status, mode: rank_mode, base: base_priority};

  spra_key_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW),
    .DW    (spra_pkg::KEY_MEM_W)
  ) u_key_mem (
    .clk   (clk),
    .we    (do_insert),
    .waddr (sidx),
    .wdata ({in_deadline, in_period}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  spra_rank_engine #(
    .MAX_TASKS (MAX_TASKS)
  ) u_rank_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .active     (active),
    .count      (active_count),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .idle       (eng_idle),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_slot   (res_slot),
    .res_prio   (res_prio),
    .res_empty  (res_empty),
    .res_status (res_status),
    .res_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, res_prio, res_slot};
  assign m_axis_tuser = {res_status, res_empty};

endmodule

// ===== tb/static_priority_rank_assigner_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench: task table events in, ranked priority lists out, predicted and compared.
module static_priority_rank_assigner_top_test;

  localparam int SLOTS       = 16;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 1500;

  typedef logic [spra_pkg::SLOT_W-1:0] slot_t;
  typedef logic [spra_pkg::PRIO_W-1:0] prio_t;
  typedef logic [spra_pkg::TIME_W-1:0] ticks_t;

  typedef struct packed {
    slot_t             task_slot;
    prio_t             prio;
    logic              empty;
    spra_pkg::status_t status;
    logic              last;
  } rank_entry_t;

  class rank_tracker;
    bit                by_deadline;
    prio_t             base_prio;
    bit                active [SLOTS];
    ticks_t            period_tab [SLOTS];
    ticks_t            deadline_tab [SLOTS];
    rank_entry_t       expected_ranks [$];
    int                failures;
    int                items;
    int                results;
    int                dup_items;
    int                miss_items;
    int                longest;

    function new();
      by_deadline = 1'b0;
      base_prio   = spra_pkg::RESET_BASE_PRIO;
      foreach (active[i]) active[i] = 1'b0;
    endfunction

    function void write_reg(spra_pkg::cfg_idx_t idx, prio_t value);
      if (idx == spra_pkg::CFG_RANK_MODE) by_deadline = value[0];
      else if (idx == spra_pkg::CFG_BASE_PRIO) base_prio = value;
    endfunction

    function ticks_t key(int s);
      return by_deadline ? deadline_tab[s] : period_tab[s];
    endfunction

    function int active_count();
      int n;
      n = 0;
      foreach (active[i]) if (active[i]) n++;
      return n;
    endfunction

    function void apply_event(logic op, slot_t slot, ticks_t per, ticks_t dl);
      spra_pkg::status_t st;
      rank_entry_t       e;
      rank_entry_t       row [SLOTS];
      int                n;
      int                r;
      int                p;
      st = spra_pkg::STATUS_OK;
      if (op == spra_pkg::OP_RELEASE) begin
        if (active[slot]) begin
          st = spra_pkg::STATUS_DUP;
        end else begin
          active[slot]       = 1'b1;
          period_tab[slot]   = per;
          deadline_tab[slot] = dl;
        end
      end else begin
        if (!active[slot]) st = spra_pkg::STATUS_MISS;
        else active[slot] = 1'b0;
      end
      items++;
      if (st == spra_pkg::STATUS_DUP) dup_items++;
      if (st == spra_pkg::STATUS_MISS) miss_items++;
      n = active_count();
      if (n == 0) begin
        e        = '0;
        e.empty  = 1'b1;
        e.status = st;
        e.last   = 1'b1;
        expected_ranks.push_back(e);
        return;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (!active[s]) continue;
        r = 0;
        for (int j = 0; j < SLOTS; j++)
          if (j != s && active[j] && (key(j) > key(s) || (key(j) == key(s) && j < s))) r++;
        p = int'(base_prio) + r;
        if (p > int'(spra_pkg::PRIO_MAX)) p = int'(spra_pkg::PRIO_MAX);
        row[r].task_slot = slot_t'(s);
        row[r].prio      = prio_t'(p);
        row[r].empty     = 1'b0;
        row[r].status    = st;
        row[r].last      = (r == n - 1);
      end
      for (int i = 0; i < n; i++) expected_ranks.push_back(row[i]);
      if (n > longest) longest = n;
    endfunction

    function void check_entry(rank_entry_t got);
      rank_entry_t want;
      results++;
      if (expected_ranks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: slot %0d prio %0d empty %0b status %0d last %0b",
                   got.task_slot, got.prio, got.empty, got.status, got.last);
        return;
      end
      want = expected_ranks.pop_front();
      if (got.task_slot !== want.task_slot || got.prio !== want.prio ||
          got.empty !== want.empty || got.status !== want.status || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch at %0t: got slot %0d prio %0d empty %0b status %0d last %0b, %s",
                   $realtime, got.task_slot, got.prio, got.empty, got.status, got.last,
                   $sformatf("expected slot %0d prio %0d empty %0b status %0d last %0b",
                             want.task_slot, want.prio, want.empty, want.status, want.last));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata = '0;  // slot, period, deadline, zero pad
  logic [0:0]         s_axis_tuser = '0;  // operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;       // task_slot, priority_res, zero pad
  logic [2:0]         m_axis_tuser;       // table_empty, status
  logic               m_axis_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  spra_pkg::cfg_idx_t cfg_index = spra_pkg::CFG_RANK_MODE;
  prio_t              cfg_data = '0;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          pressure_req = 0;
  int          pressure_seen = 0;
  int          hold_left = 0;
  rank_tracker tracker = new();

  static_priority_rank_assigner_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // hold the output for a long stretch on request, otherwise stall at random
  always @(negedge clk) begin
    if (pressure_req != pressure_seen) begin
      pressure_seen <= pressure_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    rank_entry_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.task_slot = m_axis_tdata[3:0];
      got.prio      = m_axis_tdata[9:4];
      got.empty     = m_axis_tuser[0];
      got.status    = m_axis_tuser[2:1];
      got.last      = m_axis_tlast;
      tracker.check_entry(got);
    end
  end

  function automatic ticks_t draw_ticks();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 100 * $urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(spra_pkg::cfg_idx_t idx, prio_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(logic op, slot_t slot, ticks_t per, ticks_t dl);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, dl, per, slot};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    tracker.apply_event(op, slot, per, dl);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int count);
    logic  op;
    slot_t slot;
    repeat (count) begin
      if ($urandom_range(99) < 85) begin
        if (tracker.active_count() == SLOTS ||
            (tracker.active_count() != 0 && $urandom_range(99) < 40)) begin
          op = spra_pkg::OP_FINISH;
          do slot = slot_t'($urandom_range(SLOTS - 1)); while (!tracker.active[slot]);
        end else begin
          op = spra_pkg::OP_RELEASE;
          do slot = slot_t'($urandom_range(SLOTS - 1)); while (tracker.active[slot]);
        end
      end else begin
        op   = ($urandom_range(1) != 0);
        slot = slot_t'($urandom_range(SLOTS - 1));
      end
      send_item(op, slot, draw_ticks(), draw_ticks());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(spra_pkg::OP_FINISH, slot_t'(0), '0, '0);
    send_item(spra_pkg::OP_RELEASE, slot_t'(0), '0, '1);
    send_item(spra_pkg::OP_RELEASE, slot_t'(15), '1, '0);
    send_item(spra_pkg::OP_RELEASE, slot_t'(0), 32'd5, 32'd5);
    send_item(spra_pkg::OP_RELEASE, slot_t'(7), 32'd1000, 32'd1000);
    send_item(spra_pkg::OP_RELEASE, slot_t'(3), 32'd1000, 32'd1000);
    send_item(spra_pkg::OP_FINISH, slot_t'(15), '0, '0);
    send_item(spra_pkg::OP_FINISH, slot_t'(15), '0, '0);
    for (int s = 1; s < SLOTS; s++)
      if (!tracker.active[s])
        send_item(spra_pkg::OP_RELEASE, slot_t'(s), draw_ticks(), draw_ticks());
    drain();
    write_reg(spra_pkg::CFG_RANK_MODE, 6'd1);
    write_reg(spra_pkg::CFG_BASE_PRIO, 6'd47);
    send_item(spra_pkg::OP_FINISH, slot_t'(5), '0, '0);
    send_item(spra_pkg::OP_RELEASE, slot_t'(5), 32'd1000, 32'd1000);
    drain();
    write_reg(spra_pkg::CFG_RANK_MODE, 6'd0);
    write_reg(spra_pkg::CFG_BASE_PRIO, 6'd63);
    send_item(spra_pkg::OP_RELEASE, slot_t'(9), '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_reg(spra_pkg::CFG_BASE_PRIO, 6'd0);
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
          write_reg(spra_pkg::CFG_RANK_MODE, 6'd1);
          write_reg(spra_pkg::CFG_BASE_PRIO, 6'd47);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
          write_reg(spra_pkg::CFG_RANK_MODE, 6'd0);
          write_reg(spra_pkg::CFG_BASE_PRIO, prio_t'($urandom_range(47)));
        end
        default: begin
          idle_pct  = 33;
          stall_pct = 33;
          write_reg(spra_pkg::CFG_RANK_MODE, 6'd1);
          write_reg(spra_pkg::CFG_BASE_PRIO, 6'd63);
          pressure_req++;
        end
      endcase
      run_phase(PHASE_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (tracker.expected_ranks.size() != 0) begin
      tracker.failures++;
      $display("%0d expected results never arrived", tracker.expected_ranks.size());
    end
    $display("Covered %0d table events (%0d duplicate releases, %0d finishes of idle slots),",
             tracker.items, tracker.dup_items, tracker.miss_items);
    $display("%0d ranked results, up to %0d per event, both rank modes, bases 0 to 63",
             tracker.results, tracker.longest);
    if (tracker.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/spra_pkg.sv
sv/spra_key_mem.sv
sv/spra_rank_engine.sv
sv/static_priority_rank_assigner_top.sv
tb/static_priority_rank_assigner_top_test.sv
